// ===== hdl/h2r_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`default_nettype none

package h2r_pkg;

  // hue in sixteenths of a degree
  localparam int HUE_W = 13;

  // one 60-degree sector spans 960 hue units
  localparam int SECTOR_UNITS = 960;
  localparam int FRAC_W = 10;
  localparam int SECTOR_COUNT = 6;
  localparam int SECTOR_IDX_W = 4;   // raw sector number 0..8 before the wrap

  // 960 = 64 * 15: shift first, then divide by the odd part
  localparam int UNITS_SHIFT = 6;
  localparam int UNITS_ODD = 15;

  // color wheel sectors, named by the hues they span
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// ===== hdl/h2r_sector.sv =====
// hue split into wheel sector and position within the sector
`default_nettype none

module h2r_sector
  import h2r_pkg::*;
(
  input  wire logic [HUE_W-1:0]  hue,
  output sector_t                sector,
  output logic      [FRAC_W-1:0] frac
);

  logic [SECTOR_IDX_W-1:0] idx;
  logic [HUE_W-1:0]        base;
  logic [HUE_W-1:0]        diff;

  // count the sector boundaries at or below the hue
  always_comb begin
    idx = '0;
    for (int j = 1; j <= 8; j++) begin
      if (hue >= HUE_W'(j * SECTOR_UNITS)) begin
        idx = idx + SECTOR_IDX_W'(1);
      end
    end
  end

  assign base = HUE_W'(idx) * HUE_W'(SECTOR_UNITS);
  assign diff = hue - base;
  assign frac = diff[FRAC_W-1:0];

  // hues past a full turn wrap back to the first sectors
  always_comb begin
    if (idx >= SECTOR_IDX_W'(SECTOR_COUNT)) begin
      sector = sector_t'(3'(idx - SECTOR_IDX_W'(SECTOR_COUNT)));
    end else begin
      sector = sector_t'(3'(idx));
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_divc.sv =====
// exact floor division by a constant through a rounded-up reciprocal
`default_nettype none

module h2r_divc #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 8,
  parameter int DIV   = 255
) (
  input  wire logic [IN_W-1:0]  dividend,
  output logic      [OUT_W-1:0] quot
);

  // with K = IN_W + ceil(log2 DIV) the rounded-up reciprocal is exact
  localparam int DW = $clog2(DIV);
  localparam int K  = IN_W + DW;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [IN_W:0] RECIP = RECIP_L[IN_W:0];

  logic [2*IN_W:0] prod;

  assign prod = (2*IN_W+1)'(dividend) * (2*IN_W+1)'(RECIP);
  assign quot = OUT_W'(prod >> K);

endmodule

`default_nettype wire

// ===== hdl/h2r_route.sv =====
// steers v, p, q and t onto red, green and blue by sector
`default_nettype none

module h2r_route
  import h2r_pkg::*;
#(
  parameter int COLOR_BITS = 8
) (
  input  wire sector_t                 sector,
  input  wire logic [COLOR_BITS-1:0]   v,
  input  wire logic [COLOR_BITS-1:0]   p,
  input  wire logic [COLOR_BITS-1:0]   q,
  input  wire logic [COLOR_BITS-1:0]   t,
  output logic      [COLOR_BITS-1:0]   red,
  output logic      [COLOR_BITS-1:0]   green,
  output logic      [COLOR_BITS-1:0]   blue
);

  always_comb begin
    unique case (sector)
      SEC_RED_YEL: begin red = v; green = t; blue = p; end
      SEC_YEL_GRN: begin red = q; green = v; blue = p; end
      SEC_GRN_CYN: begin red = p; green = v; blue = t; end
      SEC_CYN_BLU: begin red = p; green = q; blue = v; end
      SEC_BLU_MAG: begin red = t; green = p; blue = v; end
      default:     begin red = v; green = p; blue = q; end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_converter_top.sv =====
// hsv to rgb converter, five-stage pipeline, one pixel per clock while out_ready is high
//
// usage
//   input item: in_hue (1/16 degree, 0..5759), in_saturation and in_brightness
//   (full scale 2^COLOR_BITS-1 means 1.0), taken when in_valid and in_ready.
//   result item: out_red, out_green, out_blue, taken when out_valid and out_ready.
//   components are truncated toward zero; hue beyond 5759 wraps its sector.
// timing
//   five register stages, the last one being the output register; a result is
//   valid once its item has reached the output register. throughput is one
//   item per cycle while out_ready is high; every stage holds its own valid bit.
// stalls
//   each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and in_ready stays high while any stage is free.
//   with out_ready low the pipeline fills, then in_ready drops; nothing is
//   lost or repeated.
// reset
//   synchronous, active low rst_n clears all valid bits; payload is not reset.
`default_nettype none

module hsv_to_rgb_converter_top
  import h2r_pkg::*;
#(
  parameter int COLOR_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [HUE_W-1:0]      in_hue,
  input  wire logic [COLOR_BITS-1:0] in_saturation,
  input  wire logic [COLOR_BITS-1:0] in_brightness,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [COLOR_BITS-1:0] out_red,
  output logic      [COLOR_BITS-1:0] out_green,
  output logic      [COLOR_BITS-1:0] out_blue
);

  localparam int NSTAGE = 5;
  localparam int CB     = COLOR_BITS;
  localparam int CMAX   = (1 << COLOR_BITS) - 1;
  localparam int CFULL  = CMAX * SECTOR_UNITS;    // full scale times one sector
  localparam int PW     = CB + FRAC_W;            // s*f products and CFULL
  localparam int NW     = 2 * CB + FRAC_W;        // v * (CFULL - s*f)
  localparam int XW     = NW - UNITS_SHIFT;       // after the shift by 64
  localparam int YW     = 2 * CB;                 // numerators over full scale

  // stage valid bits and per-stage advance
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGE-1];

  // stage 1: sector and fraction
  sector_t           sec_c;
  logic [FRAC_W-1:0] frac_c;

  h2r_sector u_sector (
    .hue    (in_hue),
    .sector (sec_c),
    .frac   (frac_c)
  );

  sector_t           sec1_r;
  logic [FRAC_W-1:0] frac1_r;
  logic [CB-1:0]     sat1_r;
  logic [CB-1:0]     val1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1_r  <= sec_c;
      frac1_r <= frac_c;
      sat1_r  <= in_saturation;
      val1_r  <= in_brightness;
    end
  end

  // stage 2: s*f, s*(1-f) and v*(1-s) numerators
  logic [FRAC_W-1:0] rfrac;
  sector_t           sec2_r;
  logic [CB-1:0]     val2_r;
  logic [PW-1:0]     sf2_r;
  logic [PW-1:0]     sg2_r;
  logic [YW-1:0]     pn2_r;

  assign rfrac = FRAC_W'(SECTOR_UNITS) - frac1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2_r <= sec1_r;
      val2_r <= val1_r;
      sf2_r  <= PW'(sat1_r) * PW'(frac1_r);
      sg2_r  <= PW'(sat1_r) * PW'(rfrac);
      pn2_r  <= YW'(val1_r) * YW'(CB'(CMAX) - sat1_r);
    end
  end

  // stage 3: v * (full - s*f) and v * (full - s*(1-f))
  sector_t       sec3_r;
  logic [CB-1:0] val3_r;
  logic [NW-1:0] nq3_r;
  logic [NW-1:0] nt3_r;
  logic [YW-1:0] pn3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sec3_r <= sec2_r;
      val3_r <= val2_r;
      nq3_r  <= NW'(val2_r) * NW'(PW'(CFULL) - sf2_r);
      nt3_r  <= NW'(val2_r) * NW'(PW'(CFULL) - sg2_r);
      pn3_r  <= pn2_r;
    end
  end

  // stage 4: divide by one sector (shift by 64, then by 15)
  logic [YW-1:0] yq_c;
  logic [YW-1:0] yt_c;

  h2r_divc #(.IN_W(XW), .OUT_W(YW), .DIV(UNITS_ODD)) u_div_q (
    .dividend (nq3_r[NW-1:UNITS_SHIFT]),
    .quot     (yq_c)
  );

  h2r_divc #(.IN_W(XW), .OUT_W(YW), .DIV(UNITS_ODD)) u_div_t (
    .dividend (nt3_r[NW-1:UNITS_SHIFT]),
    .quot     (yt_c)
  );

  sector_t       sec4_r;
  logic [CB-1:0] val4_r;
  logic [YW-1:0] yq4_r;
  logic [YW-1:0] yt4_r;
  logic [YW-1:0] pn4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sec4_r <= sec3_r;
      val4_r <= val3_r;
      yq4_r  <= yq_c;
      yt4_r  <= yt_c;
      pn4_r  <= pn3_r;
    end
  end

  // stage 5: divide by full scale, route, output register
  logic [CB-1:0] p_c;
  logic [CB-1:0] q_c;
  logic [CB-1:0] t_c;
  logic [CB-1:0] red_c;
  logic [CB-1:0] green_c;
  logic [CB-1:0] blue_c;

  h2r_divc #(.IN_W(YW), .OUT_W(CB), .DIV(CMAX)) u_div_p (
    .dividend (pn4_r),
    .quot     (p_c)
  );

  h2r_divc #(.IN_W(YW), .OUT_W(CB), .DIV(CMAX)) u_div_q2 (
    .dividend (yq4_r),
    .quot     (q_c)
  );

  h2r_divc #(.IN_W(YW), .OUT_W(CB), .DIV(CMAX)) u_div_t2 (
    .dividend (yt4_r),
    .quot     (t_c)
  );

  h2r_route #(.COLOR_BITS(COLOR_BITS)) u_route (
    .sector (sec4_r),
    .v      (val4_r),
    .p      (p_c),
    .q      (q_c),
    .t      (t_c),
    .red    (red_c),
    .green  (green_c),
    .blue   (blue_c)
  );

  logic [CB-1:0] red_r;
  logic [CB-1:0] green_r;
  logic [CB-1:0] blue_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      red_r   <= red_c;
      green_r <= green_c;
      blue_r  <= blue_c;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

// ===== hdl/h2r_checker.sv =====
// port-level checks for the hsv to rgb converter and their binding
`default_nettype none

module h2r_checker
  import h2r_pkg::*;
#(
  parameter int COLOR_BITS = 8
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [HUE_W-1:0]      in_hue,
  input wire logic [COLOR_BITS-1:0] in_saturation,
  input wire logic [COLOR_BITS-1:0] in_brightness,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COLOR_BITS-1:0] out_red,
  input wire logic [COLOR_BITS-1:0] out_green,
  input wire logic [COLOR_BITS-1:0] out_blue
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a waiting input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_hue) &&
      $stable(in_saturation) && $stable(in_brightness))
    else $error("waiting input item changed or dropped");

  // a waiting result holds its pixel
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed or dropped");

  // a free output never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // the input stalls only behind a full, blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

bind hsv_to_rgb_converter_top h2r_checker #(.COLOR_BITS(COLOR_BITS)) u_h2r_checker (.*);

`default_nettype wire
